// File: src/mfa_pkg.sv
// Package for the mixed fraction adder: divider command codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package mfa_pkg;

  // Operand selects for the shared divider.
  typedef enum logic [2:0] {
    DIV_N1D1  = 3'd0,  // n1 / d1, floor split
    DIV_N2D2  = 3'd1,  // n2 / d2, floor split
    DIV_GCD   = 3'd2,  // ga % gb, Euclid step
    DIV_LCMD1 = 3'd3,  // d1 / g
    DIV_LCMD2 = 3'd4,  // lcm / d1
    DIV_MAGG  = 3'd5,  // mag / g
    DIV_DENG  = 3'd6   // lcm / g
  } div_sel_e;

  // Register load selects in the datapath.
  typedef enum logic [3:0] {
    LD_NONE   = 4'd0,
    LD_INPUT  = 4'd1,
    LD_GCD1   = 4'd2,  // ga <= d1, gb <= d2
    LD_GSTEP  = 4'd3,  // ga <= gb, gb <= rem
    LD_Q1     = 4'd4,
    LD_Q2     = 4'd5,
    LD_LCM    = 4'd6,  // lcm <= quot * d2; k2 <= quot
    LD_K2     = 4'd7,  // frac <= r1 * (lcm / d1)
    LD_FRAC   = 4'd8,
    LD_FIX    = 4'd9,  // wrap and truncation adjust
    LD_GCD2   = 4'd10, // ga <= mag, gb <= lcm
    LD_MAGQ   = 4'd11,
    LD_DENQ   = 4'd12
  } load_e;

  typedef struct packed {
    logic     div_start;
    div_sel_e div_sel;
    load_e    load;
  } mfa_cmd_t;

  typedef struct packed {
    logic div_done;
    logic gb_zero;
    logic rem_zero;
    logic bad;
  } mfa_status_t;

endpackage
`default_nettype wire

// File: src/mfa_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing; unsigned operands of parameter width.
`default_nettype none
module mfa_divider #(
  parameter int W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q_q, q_d, r_q, r_d, dv_q, dv_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;

  always_comb begin
    q_d = q_q; r_d = r_q; dv_d = dv_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {r_q, q_q[W-1]} - {1'b0, dv_q};
    if (start_i) begin
      q_d = dividend_i; r_d = '0; dv_d = divisor_i;
      cnt_d = CW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        r_d = trial[W-1:0];
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = {r_q[W-2:0], q_q[W-1]};
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;
endmodule
`default_nettype wire

// File: src/mfa_datapath.sv
// Datapath: operand registers, shared divider, one multiplier, adders.
// Depends on mfa_pkg and mfa_divider.
`default_nettype none
module mfa_datapath
  import mfa_pkg::*;
#(
  parameter int PW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic signed [PW-1:0] w1_i, n1_i, d1_i, w2_i, n2_i, d2_i,
  input  wire mfa_cmd_t             cmd_i,
  output mfa_status_t               status_o,
  output logic signed [PW+2:0]      whole_o,
  output logic signed [2*PW-2:0]    num_o,
  output logic [2*PW-3:0]           den_o
);
  localparam int DW = 2 * PW;     // divider width
  localparam int WW = PW + 3;

  logic signed [PW:0] n1_q, n2_q;   // sign-folded numerators
  logic [PW-1:0]      d1_q, d2_q;   // magnitudes, up to 2^(PW-1)
  logic signed [WW-1:0] whole_q;
  logic [DW-1:0] ga_q, gb_q, lcm_q, k2_q, frac_q, mag_q, den_q;
  logic [PW-1:0] r1_q, r2_q;
  logic          neg_q, bad_q;
  logic [DW-1:0] dvd, dvs, quot, rmd;
  logic          div_done;
  logic [PW:0]   n_abs;
  logic          n_neg;
  logic [DW-1:0] mul_a, mul_b;
  logic [2*DW-1:0] prod;
  logic signed [PW+1:0] qf;
  logic [PW-1:0] rf;
  logic [PW-1:0] dsel;
  logic [PW-1:0] dsel_r;

  // Operand mux for the shared divider.
  always_comb begin
    n_abs = '0; n_neg = 1'b0; dsel = d1_q;
    dvd = ga_q; dvs = gb_q;
    case (cmd_i.div_sel)
      DIV_N1D1, DIV_N2D2: begin
        n_neg = (cmd_i.div_sel == DIV_N1D1) ? n1_q[PW] : n2_q[PW];
        n_abs = (cmd_i.div_sel == DIV_N1D1) ?
                (n1_q[PW] ? -n1_q : n1_q) : (n2_q[PW] ? -n2_q : n2_q);
        dsel  = (cmd_i.div_sel == DIV_N1D1) ? d1_q : d2_q;
        dvd = DW'(n_abs); dvs = DW'(dsel);
      end
      DIV_GCD:   begin dvd = ga_q;      dvs = gb_q;      end
      DIV_LCMD1: begin dvd = DW'(d1_q); dvs = ga_q;      end
      DIV_LCMD2: begin dvd = lcm_q;     dvs = DW'(d1_q); end
      DIV_MAGG:  begin dvd = mag_q;     dvs = ga_q;      end
      DIV_DENG:  begin dvd = lcm_q;     dvs = ga_q;      end
      default:   begin dvd = ga_q;      dvs = gb_q;      end
    endcase
  end

  mfa_divider #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(dvd),
    .divisor_i(dvs), .done_o(div_done), .quot_o(quot), .rem_o(rmd)
  );

  // Floor split from the magnitude division; the sign register holds the
  // numerator sign captured with the divide command.
  logic sgn_q;
  always_ff @(posedge clk_i) if (cmd_i.div_start) sgn_q <= n_neg;
  always_comb begin
    if (!sgn_q) begin
      qf = (PW+2)'(quot[PW:0]);
      rf = rmd[PW-1:0];
    end else if (rmd == '0) begin
      qf = -(PW+2)'(quot[PW:0]);
      rf = '0;
    end else begin
      qf = -(PW+2)'(quot[PW:0]) - (PW+2)'(1);
      rf = PW'((dsel_r) - rmd[PW-1:0]);
    end
  end
  always_ff @(posedge clk_i) if (cmd_i.div_start) dsel_r <= dsel;

  always_comb begin
    mul_a = quot; mul_b = DW'(d2_q);
    case (cmd_i.load)
      LD_FRAC: begin mul_a = DW'(r2_q); mul_b = k2_q; end
      LD_K2:   begin mul_a = DW'(r1_q); mul_b = quot; end
      default: begin mul_a = quot; mul_b = DW'(d2_q); end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (cmd_i.load == LD_INPUT) begin
      bad_q <= (d1_i == '0) || (d2_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.load)
      LD_INPUT: begin
        n1_q <= d1_i[PW-1] ? -(PW+1)'(n1_i) : (PW+1)'(n1_i);
        n2_q <= d2_i[PW-1] ? -(PW+1)'(n2_i) : (PW+1)'(n2_i);
        d1_q <= d1_i[PW-1] ? PW'(-d1_i) : PW'(d1_i);
        d2_q <= d2_i[PW-1] ? PW'(-d2_i) : PW'(d2_i);
        whole_q <= WW'(w1_i) + WW'(w2_i);
      end
      LD_Q1: begin whole_q <= whole_q + WW'(qf); r1_q <= rf; end
      LD_Q2: begin whole_q <= whole_q + WW'(qf); r2_q <= rf; end
      LD_GCD1: begin ga_q <= DW'(d1_q); gb_q <= DW'(d2_q); end
      LD_GSTEP: begin ga_q <= gb_q; gb_q <= rmd; end
      LD_LCM: begin lcm_q <= prod[DW-1:0]; k2_q <= quot; end
      LD_K2: frac_q <= prod[DW-1:0];
      LD_FRAC: frac_q <= frac_q + prod[DW-1:0];
      LD_FIX: begin
        if (frac_q >= lcm_q) begin
          if ((whole_q + WW'(1)) < 0 && frac_q != lcm_q) begin
            whole_q <= whole_q + WW'(2);
            mag_q <= lcm_q - (frac_q - lcm_q); neg_q <= 1'b1;
          end else begin
            whole_q <= whole_q + WW'(1);
            mag_q <= frac_q - lcm_q; neg_q <= 1'b0;
          end
        end else if (whole_q < 0 && frac_q != '0) begin
          whole_q <= whole_q + WW'(1);
          mag_q <= lcm_q - frac_q; neg_q <= 1'b1;
        end else begin
          mag_q <= frac_q; neg_q <= 1'b0;
        end
      end
      LD_GCD2: begin ga_q <= mag_q; gb_q <= lcm_q; end
      LD_MAGQ: mag_q <= quot;
      LD_DENQ: den_q <= quot;
      default: ;
    endcase
  end

  // LD_K2 multiplies r1 by the fresh quotient lcm/d1; LD_FRAC adds r2*k2.
  assign status_o = '{div_done: div_done, gb_zero: (gb_q == '0),
                      rem_zero: (mag_q == '0), bad: bad_q};

  always_comb begin
    if (bad_q) begin
      whole_o = '0; num_o = '0; den_o = '0;
    end else if (mag_q == '0) begin
      whole_o = whole_q; num_o = '0; den_o = (2*PW-2)'(1);
    end else begin
      whole_o = whole_q;
      num_o = neg_q ? -(2*PW-1)'(mag_q) : (2*PW-1)'(mag_q);
      den_o = den_q[2*PW-3:0];
    end
  end
endmodule
`default_nettype wire

// File: src/mfa_controller.sv
// Controller: sequences the datapath through floor splits, GCD, LCM and
// reduction. Depends on mfa_pkg.
`default_nettype none
module mfa_controller
  import mfa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output mfa_cmd_t         cmd_o,
  input  wire mfa_status_t status_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_Q1, S_Q2, S_G1, S_G1W, S_LCMD1, S_LCMD2, S_FIX,
    S_G2, S_G2W, S_MAG, S_DEN, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;   // divider launched, awaiting done; in S_FIX, marks the second step

  always_comb begin
    state_d = state_q; busy_d = busy_q;
    cmd_o = '{div_start: 1'b0, div_sel: DIV_GCD, load: LD_NONE};
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = LD_INPUT; state_d = S_CHECK;
      end
      S_CHECK: state_d = status_i.bad ? S_OUT : S_Q1;
      S_Q1: begin
        cmd_o.div_sel = DIV_N1D1;
        if (!busy_q) begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        else if (status_i.div_done) begin
          cmd_o.load = LD_Q1; busy_d = 1'b0; state_d = S_Q2;
        end
      end
      S_Q2: begin
        cmd_o.div_sel = DIV_N2D2;
        if (!busy_q) begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        else if (status_i.div_done) begin
          cmd_o.load = LD_Q2; busy_d = 1'b0; state_d = S_G1;
        end
      end
      S_G1: begin cmd_o.load = LD_GCD1; state_d = S_G1W; end
      S_G1W: begin
        cmd_o.div_sel = DIV_GCD;
        if (!busy_q) begin
          if (status_i.gb_zero) state_d = S_LCMD1;
          else begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        end else if (status_i.div_done) begin
          cmd_o.load = LD_GSTEP; busy_d = 1'b0;
        end
      end
      S_LCMD1: begin
        cmd_o.div_sel = DIV_LCMD1;
        if (!busy_q) begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        else if (status_i.div_done) begin
          cmd_o.load = LD_LCM; busy_d = 1'b0; state_d = S_LCMD2;
        end
      end
      S_LCMD2: begin
        cmd_o.div_sel = DIV_LCMD2;
        if (!busy_q) begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        else if (status_i.div_done) begin
          cmd_o.load = LD_K2; busy_d = 1'b0; state_d = S_FIX;
        end
      end
      S_FIX: begin
        // first step adds r2*k2, second applies wrap and truncation
        if (!busy_q) begin cmd_o.load = LD_FRAC; busy_d = 1'b1; end
        else begin cmd_o.load = LD_FIX; busy_d = 1'b0; state_d = S_G2; end
      end
      S_G2: begin
        if (status_i.rem_zero) state_d = S_OUT;
        else begin cmd_o.load = LD_GCD2; state_d = S_G2W; end
      end
      S_G2W: begin
        cmd_o.div_sel = DIV_GCD;
        if (!busy_q) begin
          if (status_i.gb_zero) state_d = S_MAG;
          else begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        end else if (status_i.div_done) begin
          cmd_o.load = LD_GSTEP; busy_d = 1'b0;
        end
      end
      S_MAG: begin
        cmd_o.div_sel = DIV_DENG;
        if (!busy_q) begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        else if (status_i.div_done) begin
          cmd_o.load = LD_DENQ; busy_d = 1'b0; state_d = S_DEN;
        end
      end
      S_DEN: begin
        cmd_o.div_sel = DIV_MAGG;
        if (!busy_q) begin cmd_o.div_start = 1'b1; busy_d = 1'b1; end
        else if (status_i.div_done) begin
          cmd_o.load = LD_MAGQ; busy_d = 1'b0; state_d = S_OUT;
        end
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; busy_q <= 1'b0;
    end else begin
      state_q <= state_d; busy_q <= busy_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

`ifndef NO_ASSERTIONS
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o)) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !busy_q) else $error("divider restarted while busy");
`endif
endmodule
`default_nettype wire

// File: src/mixed_fraction_adder_unit.sv
// Top level of the mixed fraction adder: controller plus datapath.
// Depends on mfa_pkg, mfa_controller, mfa_datapath.
//
//  channel | valid       | stall       | payload
//  in      | in_valid_i  | in_stall_o  | first_*_i, second_*_i
//  out     | out_valid_o | out_stall_i | sum_*_o, bad_denominator_o
//
// One request at a time; every division runs on the shared radix-2 divider:
// two floor splits, both Euclid loops (about 22 and 43 steps at most) and
// up to four other divisions, with no division at all for a zero
// denominator. Reset is asynchronous and clears only control state and
// the bad-denominator flag. The result holds while out_stall_i is high;
// in_stall_o is high from accept until delivery.
`default_nettype none
module mixed_fraction_adder_unit
  import mfa_pkg::*;
#(
  parameter int PART_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [PART_WIDTH-1:0] first_whole_i,
  input  wire logic signed [PART_WIDTH-1:0] first_numerator_i,
  input  wire logic signed [PART_WIDTH-1:0] first_denominator_i,
  input  wire logic signed [PART_WIDTH-1:0] second_whole_i,
  input  wire logic signed [PART_WIDTH-1:0] second_numerator_i,
  input  wire logic signed [PART_WIDTH-1:0] second_denominator_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [PART_WIDTH+2:0]      sum_whole_o,
  output logic signed [2*PART_WIDTH-2:0]    sum_numerator_o,
  output logic [2*PART_WIDTH-3:0]           sum_denominator_o,
  output logic                              bad_denominator_o
);
  mfa_cmd_t    cmd;
  mfa_status_t status;

  mfa_controller u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .status_i(status)
  );

  mfa_datapath #(.PW(PART_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .w1_i(first_whole_i), .n1_i(first_numerator_i), .d1_i(first_denominator_i),
    .w2_i(second_whole_i), .n2_i(second_numerator_i),
    .d2_i(second_denominator_i),
    .cmd_i(cmd), .status_o(status),
    .whole_o(sum_whole_o), .num_o(sum_numerator_o), .den_o(sum_denominator_o)
  );

  assign bad_denominator_o = status.bad;
endmodule
`default_nettype wire

// File: test/tb_top.sv
// Testbench for mixed_fraction_adder_unit: directed and random mixed-number
// additions checked against a behavioral rational-sum predictor.
// Depends on mfa_pkg and the mixed_fraction_adder_unit RTL.
`timescale 1ns / 100ps
`default_nettype none

class sum_scoreboard;
  typedef struct packed {
    logic signed [18:0] whole;
    logic signed [30:0] numer;
    logic [29:0]        denom;
    logic               bad;
  } sum_t;

  sum_t pending_sums[$];
  int   mismatches;

  static function longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function void note_request(logic signed [15:0] w1, logic signed [15:0] n1,
                             logic signed [15:0] d1, logic signed [15:0] w2,
                             logic signed [15:0] n2, logic signed [15:0] d2);
    longint a1, b1, c1, a2, b2, c2, q1, r1, q2, r2, whole, rem;
    longint unsigned lcm, frac, g, mag, den;
    sum_t s;
    a1 = w1; b1 = n1; c1 = d1; a2 = w2; b2 = n2; c2 = d2;
    s = '0;
    if (c1 == 0 || c2 == 0) begin
      s.bad = 1'b1;
      pending_sums.push_back(s);
      return;
    end
    if (c1 < 0) begin c1 = -c1; b1 = -b1; end
    if (c2 < 0) begin c2 = -c2; b2 = -b2; end
    // floor division
    q1 = b1 / c1; r1 = b1 % c1;
    if (r1 < 0) begin q1 -= 1; r1 += c1; end
    q2 = b2 / c2; r2 = b2 % c2;
    if (r2 < 0) begin q2 -= 1; r2 += c2; end
    lcm = (c1 / gcd64(c1, c2)) * c2;
    frac = r1 * (lcm / c1) + r2 * (lcm / c2);
    whole = a1 + a2 + q1 + q2;
    if (frac >= lcm) begin
      frac -= lcm;
      whole += 1;
    end
    // truncate toward zero
    if (whole < 0 && frac != 0) begin
      whole += 1;
      rem = longint'(frac) - longint'(lcm);
    end else begin
      rem = frac;
    end
    if (rem == 0) begin
      den = 1;
    end else begin
      mag = (rem < 0) ? -rem : rem;
      g = gcd64(mag, lcm);
      mag /= g;
      den = lcm / g;
      rem = (rem < 0) ? -longint'(mag) : longint'(mag);
    end
    s.whole = whole[18:0];
    s.numer = rem[30:0];
    s.denom = den[29:0];
    pending_sums.push_back(s);
  endfunction

  function void check_result(sum_t got);
    sum_t exp;
    if (pending_sums.size() == 0) begin
      $error("result with no request outstanding");
      mismatches++;
      return;
    end
    exp = pending_sums.pop_front();
    if (got.whole !== exp.whole) begin
      $error("sum_whole exp %0d got %0d", exp.whole, got.whole);
      mismatches++;
    end
    if (got.numer !== exp.numer) begin
      $error("sum_numerator exp %0d got %0d", exp.numer, got.numer);
      mismatches++;
    end
    if (got.denom !== exp.denom) begin
      $error("sum_denominator exp %0d got %0d", exp.denom, got.denom);
      mismatches++;
    end
    if (got.bad !== exp.bad) begin
      $error("bad_denominator exp %0d got %0d", exp.bad, got.bad);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  import mfa_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [15:0] w1 = '0, n1 = '0, d1 = 16'sd1, w2 = '0, n2 = '0, d2 = 16'sd1;
  logic in_stall, out_valid, bad;
  logic signed [18:0] s_whole;
  logic signed [30:0] s_numer;
  logic [29:0] s_denom;
  logic stall_hold = 1'b0;
  int cycles = 0;
  sum_scoreboard sb;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mixed_fraction_adder_unit #(.PART_WIDTH(16)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_whole_i(w1), .first_numerator_i(n1), .first_denominator_i(d1),
    .second_whole_i(w2), .second_numerator_i(n2), .second_denominator_i(d2),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sum_whole_o(s_whole), .sum_numerator_o(s_numer),
    .sum_denominator_o(s_denom), .bad_denominator_o(bad)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  // Check results and note accepted requests at the sampling edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_result({s_whole, s_numer, s_denom, bad});
    if (rst_n && in_valid && !in_stall)
      sb.note_request(w1, n1, d1, w2, n2, d2);
  end

  // Receiver stall: random, with quiet stretches.
  always @(posedge clk) begin
    if (stall_hold) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0) && (gap_len() > 1);
  end

  task automatic send_sum(logic signed [15:0] a, logic signed [15:0] b,
                          logic signed [15:0] c, logic signed [15:0] d,
                          logic signed [15:0] e, logic signed [15:0] f);
    int gap;
    gap = gap_len();
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    w1 <= a; n1 <= b; d1 <= c; w2 <= d; n2 <= e; d2 <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_den();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      3: return 16'($urandom_range(1, 12) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_part();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 20) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero denominators, sign folding, whole sums
    send_sum(0, 0, 1, 0, 0, 1);
    send_sum(1, 1, 2, 2, 1, 2);
    send_sum(0, 1, 3, 0, 1, 6);
    send_sum(-1, 1, 2, 0, 0, 1);
    send_sum(0, -1, 2, 0, 0, 1);
    send_sum(0, 1, -2, 0, 0, 1);
    send_sum(5, 3, 0, 1, 1, 2);
    send_sum(5, 3, 4, 1, 1, 0);
    send_sum(0, 0, 0, 0, 0, 0);
    send_sum(16'sh7fff, 16'sh7fff, 1, 16'sh7fff, 16'sh7fff, 1);
    send_sum(16'sh8000, 16'sh8000, 1, 16'sh8000, 16'sh8000, 1);
    send_sum(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_sum(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_sum(0, 1, 16'sh7fff, 0, 1, 16'sh7ffe);
    send_sum(0, -1, 16'sh7fff, 0, 1, 16'sh8000);
    send_sum(3, 16'sh7fff, 16'sh7ffd, -3, 16'sh8000, 16'sh7fff);
    send_sum(-2, 1, 3, 1, 1, 3);
    send_sum(0, -1, 16'sh8000, 0, -1, 16'sh8000);
    send_sum(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

    // hold off until every result has come back
    @(posedge clk);
    while (sb.pending_sums.size() != 0) @(posedge clk);

    repeat (370) begin
      if ($urandom_range(0, 99) == 0) begin
        stall_hold = 1'b1;
        @(posedge clk);
        while (sb.pending_sums.size() != 0) @(posedge clk);
        stall_hold = 1'b0;
      end
      send_sum(rand_part(), rand_part(), rand_den(),
               rand_part(), rand_part(), rand_den());
    end

    @(posedge clk);
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
      $display("[mixed_fraction_adder_unit] OK");
    end else begin
      $display("[mixed_fraction_adder_unit] ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("[mixed_fraction_adder_unit] ERROR");
      $finish;
    end
  end
endmodule

`default_nettype wire

// File: sim.f
src/mfa_pkg.sv
src/mfa_divider.sv
src/mfa_datapath.sv
src/mfa_controller.sv
src/mixed_fraction_adder_unit.sv
test/tb_top.sv
